### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/cdc_pkg.sv
// Package for the calendar date counter: widths, codes, types and calendar helpers.
`timescale 1ns / 1ps

package cdc_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int DAY_W    = 5;
    localparam int MON_W    = 4;
    localparam int IN_DAY_W = 6;
    localparam int CNT_W    = 16;
    localparam int CMD_W    = 3;

    localparam logic [YEAR_W-1:0] YEAR_MAX   = {YEAR_W{1'b1}};
    localparam logic [YEAR_W-1:0] RESET_YEAR = YEAR_W'(2000);
    localparam logic [MON_W-1:0]  MON_JAN    = MON_W'(1);
    localparam logic [MON_W-1:0]  MON_DEC    = MON_W'(12);
    localparam logic [DAY_W-1:0]  DAY_FIRST  = DAY_W'(1);
    localparam logic [DAY_W-1:0]  DAYS_MAX   = DAY_W'(31);

    // Multiplicative inverse of an odd value modulo 2^YEAR_W (Newton steps)
    function automatic logic [YEAR_W-1:0] odd_inverse(input logic [YEAR_W-1:0] a);
        logic [YEAR_W-1:0] x;
        x = YEAR_W'(1);
        for (int i = 0; i < 5; i++) begin
            x = x * (YEAR_W'(2) - a * x);
        end
        return x;
    endfunction

    // y is a multiple of 25 exactly when y * inv(25) mod 2^W <= (2^W - 1) / 25
    localparam logic [YEAR_W-1:0] INV25     = odd_inverse(YEAR_W'(25));
    localparam logic [YEAR_W-1:0] DIV25_LIM = YEAR_W'(YEAR_MAX / 25);

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_DATE  = 3'd0,
        CMD_SET_DAY   = 3'd1,
        CMD_SET_MONTH = 3'd2,
        CMD_SET_YEAR  = 3'd3,
        CMD_ADVANCE   = 3'd4,
        CMD_COMPARE   = 3'd5
    } t_cmd;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADV,
        ST_FIN
    } t_state;

    // Days in a month; zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
            default: len = '0;
        endcase
        return len;
    endfunction

endpackage

### src/calendar_date_counter.sv
// Top level of the calendar date counter: date registers, command sequencer, result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_cmd i_in_day i_in_month i_in_year
//          |           |                            | i_day_count
//  out     | from block| o_out_valid / i_out_stall  | o_cur_day o_cur_month o_cur_year
//          |           |                            | o_accepted o_is_earlier o_is_same
//          |           |                            | o_years_apart o_overflow
//
// Set/compare: result valid two cycles after the accepting edge, next item one cycle later.
// Advance: one more cycle plus one per month boundary crossed, about 1080 for the largest
// count, set by the month-step loop around the shared month-length / day-count subtract unit.
// One item is in work at a time; the next is taken once the result sits in the output register.
// A stalled output holds the result register; a following item is worked on, then waits
// in the final state with the input stalled. Synchronous active-low reset sets 01.01.2000.
`timescale 1ns / 1ps

module calendar_date_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cdc_pkg::CMD_W-1:0]     i_cmd,
    input  logic [cdc_pkg::IN_DAY_W-1:0]  i_in_day,
    input  logic [cdc_pkg::MON_W-1:0]     i_in_month,
    input  logic [cdc_pkg::YEAR_W-1:0]    i_in_year,
    input  logic signed [cdc_pkg::CNT_W-1:0] i_day_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cdc_pkg::DAY_W-1:0]     o_cur_day,
    output logic [cdc_pkg::MON_W-1:0]     o_cur_month,
    output logic [cdc_pkg::YEAR_W-1:0]    o_cur_year,
    output logic                          o_accepted,
    output logic                          o_is_earlier,
    output logic                          o_is_same,
    output logic [cdc_pkg::YEAR_W-1:0]    o_years_apart,
    output logic                          o_overflow
);
    import cdc_pkg::*;

    // State and stored date
    t_state               r_state, n_state;
    logic [DAY_W-1:0]     r_day, n_day;
    logic [MON_W-1:0]     r_month, n_month;
    logic [YEAR_W-1:0]    r_year, n_year;

    // Captured item
    t_cmd                 r_cmd, n_cmd;
    logic [IN_DAY_W-1:0]  r_arg_day, n_arg_day;
    logic [MON_W-1:0]     r_arg_month, n_arg_month;
    logic [YEAR_W-1:0]    r_arg_year, n_arg_year;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    // Result flags of the item in work
    logic                 r_acc, n_acc;
    logic                 r_earlier, n_earlier;
    logic                 r_same, n_same;
    logic [YEAR_W-1:0]    r_apart, n_apart;
    logic                 r_ovf, n_ovf;

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic [DAY_W-1:0]     r_out_day;
    logic [MON_W-1:0]     r_out_month;
    logic [YEAR_W-1:0]    r_out_year;
    logic                 r_out_acc, r_out_earlier, r_out_same, r_out_ovf;
    logic [YEAR_W-1:0]    r_out_apart;
    logic                 w_load_out;

    // Shared date check unit operands
    logic [IN_DAY_W-1:0]  w_chk_day;
    logic [MON_W-1:0]     w_chk_month;
    logic [YEAR_W-1:0]    w_chk_year;
    logic [YEAR_W-1:0]    w_prod;
    logic                 w_div25, w_leap, w_date_ok;
    logic [DAY_W-1:0]     w_len;

    // Compare path
    logic [IN_DAY_W-1:0]  w_reg_day6;
    logic                 w_earlier, w_same, w_adj;
    logic [IN_DAY_W-1:0]  w_big_d, w_small_d;
    logic [MON_W-1:0]     w_big_m, w_small_m;
    logic [YEAR_W-1:0]    w_big_y, w_small_y, w_apart;

    // Advance path
    logic [IN_DAY_W-1:0]  w_to_next;
    logic [DAY_W-1:0]     w_room, w_cnt_lo, w_day_sum;
    logic                 w_last, w_fits, w_past_end;

    // Operand select: item fields while executing a set or compare, stored date otherwise
    always_comb begin
        w_chk_day   = {1'b0, r_day};
        w_chk_month = r_month;
        w_chk_year  = r_year;
        if (r_state == ST_EXEC) begin
            case (r_cmd) inside
                CMD_SET_DATE, CMD_COMPARE: begin
                    w_chk_day   = r_arg_day;
                    w_chk_month = r_arg_month;
                    w_chk_year  = r_arg_year;
                end
                CMD_SET_DAY:   w_chk_day   = r_arg_day;
                CMD_SET_MONTH: w_chk_month = r_arg_month;
                CMD_SET_YEAR:  w_chk_year  = r_arg_year;
                default: ;
            endcase
        end
    end

    // Leap year: divisible by 4, and not by 100 unless by 400
    assign w_prod    = YEAR_W'(w_chk_year * INV25);
    assign w_div25   = (w_prod <= DIV25_LIM);
    assign w_leap    = (w_chk_year[1:0] == 2'b00) && (!w_div25 || (w_chk_year[3:0] == 4'b0000));
    assign w_len     = month_len(w_chk_month, w_leap);
    // every YEAR_W-bit year is in range, so only day and month need checking
    assign w_date_ok = (w_chk_day != '0) && (w_chk_day <= {1'b0, w_len});

    // Compare stored date against the item's date
    assign w_reg_day6 = {1'b0, r_day};
    assign w_same     = (r_year == r_arg_year) && (r_month == r_arg_month)
                        && (w_reg_day6 == r_arg_day);
    always_comb begin
        if (r_year != r_arg_year) begin
            w_earlier = (r_year < r_arg_year);
        end else if (r_month != r_arg_month) begin
            w_earlier = (r_month < r_arg_month);
        end else begin
            w_earlier = (w_reg_day6 < r_arg_day);
        end
    end
    assign w_big_d   = w_earlier ? r_arg_day   : w_reg_day6;
    assign w_big_m   = w_earlier ? r_arg_month : r_month;
    assign w_big_y   = w_earlier ? r_arg_year  : r_year;
    assign w_small_d = w_earlier ? w_reg_day6  : r_arg_day;
    assign w_small_m = w_earlier ? r_month     : r_arg_month;
    assign w_small_y = w_earlier ? r_year      : r_arg_year;
    // anniversary not reached yet in the later year
    assign w_adj     = (w_big_m < w_small_m) || ((w_big_m == w_small_m) && (w_big_d < w_small_d));
    assign w_apart   = w_big_y - w_small_y - YEAR_W'(w_adj);

    // Month step: days until the first of next month, or room left in the last month
    assign w_to_next  = {1'b0, w_len} - {1'b0, r_day} + IN_DAY_W'(1);
    assign w_last     = (r_month == MON_DEC) && (r_year == YEAR_MAX);
    assign w_room     = DAYS_MAX - r_day;
    assign w_cnt_lo   = r_cnt[DAY_W-1:0];
    assign w_day_sum  = r_day + w_cnt_lo;
    assign w_fits     = (r_cnt < CNT_W'(w_to_next));
    assign w_past_end = (r_cnt > CNT_W'(w_room));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and next values
    always_comb begin
        n_state     = r_state;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_cmd       = r_cmd;
        n_arg_day   = r_arg_day;
        n_arg_month = r_arg_month;
        n_arg_year  = r_arg_year;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_earlier   = r_earlier;
        n_same      = r_same;
        n_apart     = r_apart;
        n_ovf       = r_ovf;
        w_load_out  = 1'b0;
        o_in_stall  = (r_state != ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd       = t_cmd'(i_cmd);
                    n_arg_day   = i_in_day;
                    n_arg_month = i_in_month;
                    n_arg_year  = i_in_year;
                    n_cnt       = $unsigned(i_day_count);
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_acc     = 1'b0;
                n_earlier = 1'b0;
                n_same    = 1'b0;
                n_apart   = '0;
                n_ovf     = 1'b0;
                n_state   = ST_FIN;
                unique case (r_cmd)
                    CMD_SET_DATE: begin
                        if (w_date_ok) begin
                            n_day   = w_chk_day[DAY_W-1:0];
                            n_month = r_arg_month;
                            n_year  = r_arg_year;
                            n_acc   = 1'b1;
                        end
                    end
                    CMD_SET_DAY: begin
                        if (w_date_ok) begin
                            n_day = w_chk_day[DAY_W-1:0];
                            n_acc = 1'b1;
                        end
                    end
                    CMD_SET_MONTH: begin
                        if (w_date_ok) begin
                            n_month = r_arg_month;
                            n_acc   = 1'b1;
                        end
                    end
                    CMD_SET_YEAR: begin
                        if (w_date_ok) begin
                            n_year = r_arg_year;
                            n_acc  = 1'b1;
                        end
                    end
                    CMD_ADVANCE: begin
                        if (!r_cnt[CNT_W-1]) begin
                            n_acc   = 1'b1;
                            n_state = ST_ADV;
                        end
                    end
                    CMD_COMPARE: begin
                        if (w_date_ok) begin
                            n_acc     = 1'b1;
                            n_earlier = w_earlier;
                            n_same    = w_same;
                            n_apart   = w_apart;
                        end
                    end
                    default: ;
                endcase
            end
            ST_ADV: begin
                if (w_last) begin
                    // last representable month: land inside it or stop at its end
                    n_state = ST_FIN;
                    if (w_past_end) begin
                        n_day = DAYS_MAX;
                        n_ovf = 1'b1;
                    end else begin
                        n_day = w_day_sum;
                    end
                end else if (w_fits) begin
                    n_day   = w_day_sum;
                    n_state = ST_FIN;
                end else begin
                    // jump to the first of next month
                    n_cnt = r_cnt - CNT_W'(w_to_next);
                    n_day = DAY_FIRST;
                    if (r_month == MON_DEC) begin
                        n_month = MON_JAN;
                        n_year  = r_year + YEAR_W'(1);
                    end else begin
                        n_month = r_month + MON_W'(1);
                    end
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid follows load and take
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Date and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= DAY_FIRST;
            r_month     <= MON_JAN;
            r_year      <= RESET_YEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_out_valid <= n_out_valid;
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_arg_day   <= n_arg_day;
        r_arg_month <= n_arg_month;
        r_arg_year  <= n_arg_year;
        r_cnt       <= n_cnt;
        r_acc       <= n_acc;
        r_earlier   <= n_earlier;
        r_same      <= n_same;
        r_apart     <= n_apart;
        r_ovf       <= n_ovf;
        if (w_load_out) begin
            r_out_day     <= r_day;
            r_out_month   <= r_month;
            r_out_year    <= r_year;
            r_out_acc     <= r_acc;
            r_out_earlier <= r_earlier;
            r_out_same    <= r_same;
            r_out_apart   <= r_apart;
            r_out_ovf     <= r_ovf;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cur_day     = r_out_day;
    assign o_cur_month   = r_out_month;
    assign o_cur_year    = r_out_year;
    assign o_accepted    = r_out_acc;
    assign o_is_earlier  = r_out_earlier;
    assign o_is_same     = r_out_same;
    assign o_years_apart = r_out_apart;
    assign o_overflow    = r_out_ovf;

endmodule

### src/cdc_checker.sv
// Port-level checker for the calendar date counter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [cdc_pkg::DAY_W-1:0]  o_cur_day,
    input logic [cdc_pkg::MON_W-1:0]  o_cur_month,
    input logic [cdc_pkg::YEAR_W-1:0] o_cur_year,
    input logic                       o_accepted,
    input logic                       o_is_earlier,
    input logic                       o_is_same,
    input logic [cdc_pkg::YEAR_W-1:0] o_years_apart,
    input logic                       o_overflow
);
    import cdc_pkg::*;

    // Reported date has a month in 1..12 and a day of at least 1
    `ASSERT_IMP(a_date_shape, i_clk, i_rst_n, o_out_valid, (o_cur_month >= MON_JAN) && (o_cur_month <= MON_DEC) && (o_cur_day >= DAY_FIRST))

    // A rejected item carries no compare or overflow result
    `ASSERT_IMP(a_reject_clean, i_clk, i_rst_n, o_out_valid && !o_accepted, !o_is_earlier && !o_is_same && !o_overflow && (o_years_apart == '0))

    // Overflow only when parked on the last representable date
    `ASSERT_IMP(a_ovf_at_end, i_clk, i_rst_n, o_out_valid && o_overflow, o_accepted && (o_cur_day == DAYS_MAX) && (o_cur_month == MON_DEC) && (o_cur_year == YEAR_MAX))

    // Equal dates are neither earlier nor any years apart
    `ASSERT_IMP(a_same_excl, i_clk, i_rst_n, o_out_valid && o_is_same, !o_is_earlier && (o_years_apart == '0))

    // A stalled result holds its valid, day, year and accepted flag
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_cur_day) && $stable(o_cur_year) && $stable(o_accepted))

endmodule

bind calendar_date_counter cdc_checker u_cdc_checker (.*);
